[sv/q2e_pkg.sv]
// Package for the quaternion to Euler angle converter.
// Holds the shared types, fixed-point constants, the CORDIC angle table and the
// per-stage step functions. Depends on nothing.
package q2e_pkg;

  // Requested CORDIC depth and the depth actually built (the table has 24 entries).
  localparam int CORDIC_STAGES = 16;
  localparam int ANG_TABLE_LEN = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < ANG_TABLE_LEN) ? CORDIC_STAGES : ANG_TABLE_LEN;

  // Square root: one result bit per stage, radicand at most 2^56.
  localparam int SQ_STEPS = 29;

  localparam logic signed [33:0] ONE_Q28     = 34'sd268435456;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [16:0] PI_Q13      = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [33:0] ROUND_HALF  = 34'sd65536;

  // Operands that ride alongside the square root stages.
  typedef struct packed {
    logic signed [33:0] sr;
    logic signed [33:0] cr;
    logic signed [33:0] sp;
    logic signed [33:0] sy;
    logic signed [33:0] cy;
    logic               sat_p;
    logic               sat_n;
  } side_t;

  // One square root stage: remainder and partial root.
  typedef struct packed {
    logic [57:0] n;
    logic [57:0] r;
  } sq_t;

  // One CORDIC lane: vector, accumulated angle and the origin flag.
  typedef struct packed {
    logic signed [37:0] x;
    logic signed [37:0] y;
    logic signed [33:0] acc;
    logic               zero;
  } cord_t;

  // atan(2^-i) in Q30 radians.
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    case (i)
      0:  v = 34'sh3243F6A8;
      1:  v = 34'sh1DAC6705;
      2:  v = 34'sh0FADBAFC;
      3:  v = 34'sh07F56EA6;
      4:  v = 34'sh03FEAB76;
      5:  v = 34'sh01FFD55B;
      6:  v = 34'sh00FFFAAA;
      7:  v = 34'sh007FFF55;
      8:  v = 34'sh003FFFEA;
      9:  v = 34'sh001FFFFD;
      10: v = 34'sh000FFFFF;
      11: v = 34'sh0007FFFF;
      12: v = 34'sh0003FFFF;
      13: v = 34'sh0001FFFF;
      14: v = 34'sh0000FFFF;
      15: v = 34'sh00007FFF;
      16: v = 34'sh00003FFF;
      17: v = 34'sh00001FFF;
      18: v = 34'sh00000FFF;
      19: v = 34'sh000007FF;
      20: v = 34'sh000003FF;
      21: v = 34'sh000001FF;
      22: v = 34'sh000000FF;
      23: v = 34'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // One digit of the integer square root, trial bit 4^k.
  function automatic sq_t sqrt_step(input sq_t s, input int k);
    sq_t         o;
    logic [57:0] bitv;
    logic [57:0] trial;
    bitv  = 58'(1) << (2 * k);
    trial = s.r + bitv;
    if (s.n >= trial) begin
      o.n = s.n - trial;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.n = s.n;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // Fold the left half plane onto the right half before the rotations.
  function automatic cord_t cord_init(input logic signed [37:0] y, input logic signed [37:0] x);
    cord_t c;
    c.zero = (x == '0) && (y == '0);
    c.acc  = '0;
    c.x    = x;
    c.y    = y;
    if (x < 0) begin
      if (y >= 0) begin
        c.x   = y;
        c.y   = -x;
        c.acc = HALF_PI_Q30;
      end else begin
        c.x   = -y;
        c.y   = x;
        c.acc = -HALF_PI_Q30;
      end
    end
    return c;
  endfunction

  // One vectoring micro-rotation with shift i.
  function automatic cord_t cord_step(input cord_t c, input int i);
    cord_t              o;
    logic signed [37:0] xs;
    logic signed [37:0] ys;
    xs     = c.x >>> i;
    ys     = c.y >>> i;
    o.zero = c.zero;
    if (c.y >= 0) begin
      o.x   = c.x + ys;
      o.y   = c.y - xs;
      o.acc = c.acc + atan_q30(i);
    end else begin
      o.x   = c.x - ys;
      o.y   = c.y + xs;
      o.acc = c.acc - atan_q30(i);
    end
    return o;
  endfunction

  // Round Q30 to Q3.13 half up, then clamp to plus or minus lim.
  function automatic logic signed [16:0] to_q13(input logic signed [33:0] a,
                                                input logic signed [16:0] lim);
    logic signed [33:0] t;
    logic signed [16:0] r;
    t = (a + ROUND_HALF) >>> 17;
    r = t[16:0];
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

[sv/quaternion_to_euler_unit.sv]
// Quaternion to Euler angle converter, fully pipelined.
// Uses q2e_pkg for types, constants, the square root step and the CORDIC steps.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one quaternion beat with
//   components x, y, z, w in signed Q2.14. The output channel
//   (out_valid/out_ready) gives one beat with pitch and roll in signed Q3.13
//   radians and yaw in signed Q2.13 radians, limited to plus or minus pi/2.
//   Throughput is one beat per cycle. The stages are, in order: products,
//   sums, the cosine factors, the radicand, the bit-per-stage square root
//   for the yaw cosine, one quadrant fold, one CORDIC rotation per stage and
//   the output register. The square root chain sets the latency; all three
//   angles share the CORDIC depth.
//   The whole pipeline advances together: when out_valid is high and
//   out_ready is low every stage holds and in_ready drops, so no beat is
//   lost or repeated. Empty stages move on while the output is free.
//   Synchronous active-low reset clears all valid bits; the data registers
//   are not reset.
module quaternion_to_euler_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [14:0] out_yaw_angle,
  output logic signed [15:0] out_roll_angle
);

  localparam int NS = q2e_pkg::NUM_STAGES;
  localparam int SQ = q2e_pkg::SQ_STEPS;
  localparam int NV = 4 + SQ + 1 + NS + 1;

  logic [NV-1:0] v_r;
  logic          en;

  // Stage 1 products.
  logic signed [31:0] wx_r, yz_r, wy_r, zx_r, wz_r, xy_r, xx_r, yy_r, zz_r;
  // Stage 2 sums.
  logic signed [33:0] sr_r, cr_r, sp_r, sy_r, cy_r;
  // Stage 3 cosine factors.
  q2e_pkg::side_t     sd3_r;
  logic [29:0]        pa_r, pb_r;
  logic [59:0]        prod_c;
  // Square root chain and side operands.
  q2e_pkg::sq_t       sq_r [0:SQ];
  q2e_pkg::side_t     sd_r [0:SQ];
  // CORDIC lanes.
  q2e_pkg::cord_t     cp_r [0:NS];
  q2e_pkg::cord_t     cw_r [0:NS];
  q2e_pkg::cord_t     cl_r [0:NS];
  logic [1:0]         sat_r [0:NS];
  // Output register.
  logic signed [15:0] pitch_r, roll_r;
  logic signed [14:0] yaw_r;
  logic signed [16:0] pitch_c, yaw_c, roll_c;
  logic signed [37:0] yaw_x_c;

  // The pipeline moves whenever the output beat is empty or being taken.
  assign en       = !v_r[NV-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NV-2:0], in_valid};
    end
  end

  assign prod_c  = pa_r * pb_r;
  assign yaw_x_c = 38'(signed'({1'b0, sq_r[SQ].r[28:0]}));

  // Final rounding and clamping, with the origin and saturated-sine cases.
  always_comb begin
    pitch_c = cp_r[NS].zero ? 17'sd0 : q2e_pkg::to_q13(cp_r[NS].acc, q2e_pkg::PI_Q13);
    roll_c  = cl_r[NS].zero ? 17'sd0 : q2e_pkg::to_q13(cl_r[NS].acc, q2e_pkg::PI_Q13);
    if (sat_r[NS][1]) begin
      yaw_c = q2e_pkg::HALF_PI_Q13;
    end else if (sat_r[NS][0]) begin
      yaw_c = -q2e_pkg::HALF_PI_Q13;
    end else if (cw_r[NS].zero) begin
      yaw_c = 17'sd0;
    end else begin
      yaw_c = q2e_pkg::to_q13(cw_r[NS].acc, q2e_pkg::HALF_PI_Q13);
    end
  end

  // Datapath registers, all advancing on the common enable.
  always_ff @(posedge clk) begin
    if (en) begin
      // Products.
      wx_r <= in_quat_w * in_quat_x;
      yz_r <= in_quat_y * in_quat_z;
      wy_r <= in_quat_w * in_quat_y;
      zx_r <= in_quat_z * in_quat_x;
      wz_r <= in_quat_w * in_quat_z;
      xy_r <= in_quat_x * in_quat_y;
      xx_r <= in_quat_x * in_quat_x;
      yy_r <= in_quat_y * in_quat_y;
      zz_r <= in_quat_z * in_quat_z;
      // Sines and cosines in Q28.
      sr_r <= (34'(wx_r) + 34'(yz_r)) <<< 1;
      cr_r <= q2e_pkg::ONE_Q28 - ((34'(xx_r) + 34'(yy_r)) <<< 1);
      sp_r <= (34'(wy_r) - 34'(zx_r)) <<< 1;
      sy_r <= (34'(wz_r) + 34'(xy_r)) <<< 1;
      cy_r <= q2e_pkg::ONE_Q28 - ((34'(yy_r) + 34'(zz_r)) <<< 1);
      // Saturation check and the factors of 1 - s^2.
      sd3_r.sr    <= sr_r;
      sd3_r.cr    <= cr_r;
      sd3_r.sp    <= sp_r;
      sd3_r.sy    <= sy_r;
      sd3_r.cy    <= cy_r;
      sd3_r.sat_p <= sp_r >= q2e_pkg::ONE_Q28;
      sd3_r.sat_n <= sp_r <= -q2e_pkg::ONE_Q28;
      if ((sp_r >= q2e_pkg::ONE_Q28) || (sp_r <= -q2e_pkg::ONE_Q28)) begin
        pa_r <= '0;
        pb_r <= '0;
      end else begin
        pa_r <= 30'(q2e_pkg::ONE_Q28 - sp_r);
        pb_r <= 30'(q2e_pkg::ONE_Q28 + sp_r);
      end
      // Radicand enters the square root chain.
      sq_r[0].n <= prod_c[57:0];
      sq_r[0].r <= '0;
      sd_r[0]   <= sd3_r;
      // One root bit per stage, most significant first.
      for (int s = 0; s < SQ; s++) begin
        sq_r[s+1] <= q2e_pkg::sqrt_step(sq_r[s], SQ - 1 - s);
        sd_r[s+1] <= sd_r[s];
      end
      // Quadrant fold for the three lanes.
      cp_r[0]  <= q2e_pkg::cord_init(38'(sd_r[SQ].sr), 38'(sd_r[SQ].cr));
      cw_r[0]  <= q2e_pkg::cord_init(38'(sd_r[SQ].sp), yaw_x_c);
      cl_r[0]  <= q2e_pkg::cord_init(38'(sd_r[SQ].sy), 38'(sd_r[SQ].cy));
      sat_r[0] <= {sd_r[SQ].sat_p, sd_r[SQ].sat_n};
      // CORDIC rotations, one per stage.
      for (int i = 0; i < NS; i++) begin
        cp_r[i+1]  <= q2e_pkg::cord_step(cp_r[i], i);
        cw_r[i+1]  <= q2e_pkg::cord_step(cw_r[i], i);
        cl_r[i+1]  <= q2e_pkg::cord_step(cl_r[i], i);
        sat_r[i+1] <= sat_r[i];
      end
      // Output beat.
      pitch_r <= pitch_c[15:0];
      yaw_r   <= yaw_c[14:0];
      roll_r  <= roll_c[15:0];
    end
  end

  assign out_valid       = v_r[NV-1];
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle   = yaw_r;
  assign out_roll_angle  = roll_r;

endmodule

[sv/q2e_checker.sv]
// Port-level checker for the quaternion to Euler angle converter.
// Depends on nothing but the top level's ports; bound to the top level below.
module q2e_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [15:0] in_quat_x,
  input logic signed [15:0] in_quat_y,
  input logic signed [15:0] in_quat_z,
  input logic signed [15:0] in_quat_w,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_pitch_angle,
  input logic signed [14:0] out_yaw_angle,
  input logic signed [15:0] out_roll_angle
);

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present right after reset");

  // A stalled output beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pitch_angle)
      && $stable(out_yaw_angle) && $stable(out_roll_angle))
    else $error("stalled output beat changed");

  // An empty output never blocks the input.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // Yaw stays within plus or minus pi/2.
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_angle <= 15'sd12868) && (out_yaw_angle >= -15'sd12868))
    else $error("yaw beyond pi/2");

  // Pitch and roll stay within plus or minus pi.
  a_pr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= 16'sd25736) && (out_pitch_angle >= -16'sd25736)
      && (out_roll_angle <= 16'sd25736) && (out_roll_angle >= -16'sd25736))
    else $error("pitch or roll beyond pi");

endmodule

bind quaternion_to_euler_unit q2e_checker u_q2e_checker (.*);

[tb/quaternion_to_euler_unit_tb.sv]
// Testbench for the quaternion to Euler angle converter.
// Predicts pitch, yaw and roll with its own CORDIC and root model and checks each beat.
// Depends on q2e_pkg and quaternion_to_euler_unit.
module quaternion_to_euler_unit_tb;

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [14:0] yaw;
    logic signed [15:0] roll;
  } angles_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_quat_x;
  logic signed [15:0] in_quat_y;
  logic signed [15:0] in_quat_z;
  logic signed [15:0] in_quat_w;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_pitch_angle;
  logic signed [14:0] out_yaw_angle;
  logic signed [15:0] out_roll_angle;

  angles_t angle_queue[$];
  int      error_count;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_cycles;
  int      quiet_cycles;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY        = 35 + q2e_pkg::NUM_STAGES;

  quaternion_to_euler_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_quat_x(in_quat_x), .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z), .in_quat_w(in_quat_w),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pitch_angle(out_pitch_angle), .out_yaw_angle(out_yaw_angle),
    .out_roll_angle(out_roll_angle)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Arctangent table in Q30 radians.
  function automatic longint arc_step(int i);
    longint t[24];
    t = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
          64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
          64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
          64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
          64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return t[i];
  endfunction

  // Vectoring rotation: angle of (xv, yv) in Q30 radians.
  function automatic longint vector_angle(longint yv, longint xv);
    longint acc;
    longint tmp;
    longint xs;
    longint ys;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        tmp = yv; yv = -xv; acc = 1686629713;
      end else begin
        tmp = -yv; yv = xv; acc = -1686629713;
      end
      xv = tmp;
    end
    for (int i = 0; i < q2e_pkg::NUM_STAGES; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys; yv = yv - xs; acc += arc_step(i);
      end else begin
        xv = xv - ys; yv = yv + xs; acc -= arc_step(i);
      end
    end
    return acc;
  endfunction

  // Round Q30 to Q3.13 half up and clamp.
  function automatic longint round_clamp(longint a, longint lim);
    longint r;
    r = (a + 65536) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Expected Euler angles for one quaternion.
  function automatic angles_t euler_of(logic signed [15:0] qx, logic signed [15:0] qy,
                                       logic signed [15:0] qz, logic signed [15:0] qw);
    angles_t e;
    longint  x, y, z, w, sr, cr, sp, sy, cy, c, yaw;
    longint  one;
    one = 268435456;
    x = qx; y = qy; z = qz; w = qw;
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    if (sp >= one) yaw = 12868;
    else if (sp <= -one) yaw = -12868;
    else begin
      c = int_root(longint'(one - sp) * longint'(one + sp));
      yaw = round_clamp(vector_angle(sp, c), 12868);
    end
    e.pitch = 16'(round_clamp(vector_angle(sr, cr), 25736));
    e.yaw   = 15'(yaw);
    e.roll  = 16'(round_clamp(vector_angle(sy, cy), 25736));
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Send one beat; valid stays high across back-to-back beats.
  task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_quat_x <= qx;
    in_quat_y <= qy;
    in_quat_z <= qz;
    in_quat_w <= qw;
    angle_queue.push_back(euler_of(qx, qy, qz, qw));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (angle_queue.size() != 0) @(negedge clk);
  endtask

  // Mostly near-unit quaternions built from random normalized components, some raw noise.
  task automatic send_random(int n);
    real a, b, c, d, m;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        a = $urandom_range(20000) - 10000.0;
        b = $urandom_range(20000) - 10000.0;
        c = $urandom_range(20000) - 10000.0;
        d = $urandom_range(20000) - 10000.0;
        m = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        send_quat(16'($rtoi(a / m * 16384.0)), 16'($rtoi(b / m * 16384.0)),
                  16'($rtoi(c / m * 16384.0)), 16'($rtoi(d / m * 16384.0)));
      end
    end
  endtask

  task automatic test_directed();
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
    // Sine just beyond plus and minus one, and well beyond.
    send_quat(16'sd0, 16'sd11585, 16'sd0, 16'sd11586);
    send_quat(16'sd0, -16'sd11586, 16'sd0, 16'sd11586);
    send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd32767);
    send_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_quat(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
    send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd12000, 16'sd12000, 16'sd0);
    wait_drained();
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    hold_cycles = 200;
    send_random(150);
    wait_drained();
  endtask

  task automatic test_random_idle();
    send_idle_pct = 29; recv_idle_pct = 56;
    send_random(600);
    send_idle_pct = 56; recv_idle_pct = 29;
    send_random(600);
    send_idle_pct = 0; recv_idle_pct = 0;
    send_random(480);
    wait_drained();
  endtask

  // Receiver ready, with random stalls and an optional long hold-off.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    angles_t e;
    if (rst_n && out_valid && out_ready) begin
      if (angle_queue.size() == 0) begin
        report_mismatch("unexpected beat", out_pitch_angle, 0);
      end else begin
        e = angle_queue.pop_front();
        if (out_pitch_angle !== e.pitch) report_mismatch("pitch", out_pitch_angle, e.pitch);
        if (out_yaw_angle !== e.yaw) report_mismatch("yaw", out_yaw_angle, e.yaw);
        if (out_roll_angle !== e.roll) report_mismatch("roll", out_roll_angle, e.roll);
      end
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0; in_valid = 1'b0;
    in_quat_x = '0; in_quat_y = '0; in_quat_z = '0; in_quat_w = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_idle();
    repeat (LATENCY + 20) @(negedge clk);
    if (error_count == 0 && angle_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[quaternion_to_euler_unit.f]
sv/q2e_pkg.sv
sv/quaternion_to_euler_unit.sv
sv/q2e_checker.sv
tb/quaternion_to_euler_unit_tb.sv
